@@ design/wrps_pkg.sv @@
// Package for the weighted random priority scheduler.
// Holds the sequencer state type, status and action codes, the reciprocal constants
// and the level-picking function. Depends on nothing else.
`timescale 1ns / 1ps

package wrps_pkg;

	localparam int NUM_LEVELS = 10;
	localparam int LEVEL_W    = 4;
	localparam int ID_W       = 32;
	localparam int RAND_W     = 14;
	localparam int PICK_W     = 7;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 40;

	localparam logic [RAND_W-1:0] RANDOM_SEED = 14'd3251;

	// Reciprocals for exact floor division by a constant: q = (x * M) >> S.
	localparam logic [31:0] RECIP_100   = 32'd343597384;
	localparam int          SHIFT_100   = 35;
	localparam logic [31:0] RECIP_10000 = 32'd6871948;
	localparam int          SHIFT_10000 = 36;
	localparam logic [31:0] RECIP_101   = 32'd10382;
	localparam int          SHIFT_101   = 20;
	localparam logic [31:0] CONST_10000 = 32'd10000;
	localparam logic [31:0] CONST_101   = 32'd101;

	localparam logic ACT_ENQUEUE = 1'b0;
	localparam logic ACT_DEQUEUE = 1'b1;

	typedef enum logic [2:0] {
		STAT_ENQUEUED = 3'd0,
		STAT_DEQUEUED = 3'd1,
		STAT_BAD_PRIO = 3'd2,
		STAT_EMPTY    = 3'd3,
		STAT_FULL     = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ENQ,
		ST_SQUARE,
		ST_DIV100,
		ST_DIV10K,
		ST_MOD10K,
		ST_DIV101,
		ST_MOD101,
		ST_PICK,
		ST_OUT
	} state_t;

	// Upper bounds of the weighted bins for levels 0 to 8; anything above is level 9.
	localparam logic [PICK_W-1:0] LEVEL_BOUND [NUM_LEVELS-1] = '{
		7'd2, 7'd4, 7'd7, 7'd11, 7'd18, 7'd28, 7'd39, 7'd50, 7'd65
	};

	function automatic logic [LEVEL_W-1:0] pick_level(input logic [PICK_W-1:0] p);
		logic [LEVEL_W-1:0] lv;
		lv = LEVEL_W'(NUM_LEVELS - 1);
		for (int k = NUM_LEVELS - 2; k >= 0; k--) begin
			if (p <= LEVEL_BOUND[k]) begin
				lv = LEVEL_W'(k);
			end
		end
		return lv;
	endfunction

endpackage

@@ design/wrps_queue_mem.sv @@
// Single-port-write, single-port-read storage for all level queues.
// Read data is registered. Uses no package.
`timescale 1ns / 1ps

module wrps_queue_mem #(
	parameter int WORDS  = 160,
	parameter int ADDR_W = 8,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/weighted_random_priority_scheduler_unit.sv @@
// Top level of the weighted random priority scheduler: ten bounded FIFO queues of ids,
// served by a middle-square random draw. Depends on wrps_pkg and wrps_queue_mem.
//
//   channel  dir  tdata (low bit up)                         tuser
//   s_*      in   process_id[31:0], priority_req[35:32], pad  action
//   m_*      out  served_id[31:0], served_level[35:32], pad   status
//
// An enqueue passes through ST_ENQ and ST_OUT; a dequeue through ST_SQUARE to ST_MOD101, ST_PICK, ST_OUT.
// The dequeue time is set by six passes through one shared 32x32 multiplier (square, then
// reciprocal divides and remainders) plus one level search and a registered memory read.
// One item is worked at a time; s_tready is high again once the result sits in the output
// register, so a new item can enter while that result waits for m_tready.
// Reset clears counts, pointers and the random state at once; queue storage is not cleared.
`timescale 1ns / 1ps

module weighted_random_priority_scheduler_unit #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// process_id [31:0], priority_req [35:32], zero pad [39:36]
	input  logic [wrps_pkg::IN_TDATA_W-1:0]     s_tdata,
	// action [0]
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// served_id [31:0], served_level [35:32], zero pad [39:36]
	output logic [wrps_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// status [2:0]
	output logic [2:0]                          m_tuser
);

	import wrps_pkg::*;

	localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int WORDS  = NUM_LEVELS * QUEUE_DEPTH;
	localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;

	state_t state_q, state_next;

	logic [CNT_W-1:0] count_q [NUM_LEVELS];
	logic [PTR_W-1:0] head_q  [NUM_LEVELS];
	logic [PTR_W-1:0] tail_q  [NUM_LEVELS];
	logic [RAND_W-1:0] rand_q;

	logic              act_q;
	logic [ID_W-1:0]   pid_q;
	logic [3:0]        prio_q;

	logic [27:0]       wk_q;
	logic [21:0]       quo_q;
	logic [PICK_W-1:0] pick_val_q;

	logic [LEVEL_W-1:0] res_level_q;
	status_t            res_status_q;

	logic              m_valid_q;
	logic [ID_W-1:0]   m_id_q;
	logic [LEVEL_W-1:0] m_level_q;
	status_t           m_status_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	logic               mem_we, mem_re;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
	logic [ID_W-1:0]    mem_rdata;

	logic               in_accept, out_load;

	// Enqueue side.
	logic               prio_ok;
	logic [LEVEL_W-1:0] enq_lv;
	logic [CNT_W-1:0]   enq_cnt;
	logic [PTR_W-1:0]   enq_tail;
	logic               enq_full;

	// Dequeue side.
	logic [LEVEL_W-1:0]    pick_lv;
	logic [NUM_LEVELS-1:0] nonempty, up_mask;
	logic [LEVEL_W-1:0]    up_sel, any_sel, sel_lv;
	logic                  found;
	logic [21:0]           mod10k_diff;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] ptr);
		logic [PTR_W-1:0] nxt;
		if (ptr == PTR_W'(QUEUE_DEPTH - 1)) begin
			nxt = '0;
		end else begin
			nxt = ptr + PTR_W'(1);
		end
		return nxt;
	endfunction

	assign in_accept = s_tvalid && s_tready;
	assign out_load  = (state_q == ST_OUT) && (!m_valid_q || m_tready);

	assign prod = 64'(mul_a) * 64'(mul_b);

	// Enqueue checks; an out-of-range level is kept off the count and tail muxes.
	assign prio_ok  = (prio_q >= 4'd1) && (prio_q <= 4'(NUM_LEVELS));
	assign enq_lv   = prio_ok ? (prio_q - 4'd1) : '0;
	assign enq_cnt  = count_q[enq_lv];
	assign enq_tail = tail_q[enq_lv];
	assign enq_full = (enq_cnt == CNT_W'(QUEUE_DEPTH));

	assign mod10k_diff = quo_q - prod[21:0];

	// Search the first non-empty level from the pick upward; if none, the highest below.
	assign pick_lv = pick_level(pick_val_q);

	always_comb begin
		for (int i = 0; i < NUM_LEVELS; i++) begin
			nonempty[i] = (count_q[i] != '0);
			up_mask[i]  = nonempty[i] && (LEVEL_W'(i) >= pick_lv);
		end
	end

	always_comb begin
		up_sel  = '0;
		any_sel = '0;
		for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
			if (up_mask[i]) begin
				up_sel = LEVEL_W'(i);
			end
		end
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (nonempty[i]) begin
				any_sel = LEVEL_W'(i);
			end
		end
	end

	assign found  = |nonempty;
	assign sel_lv = (|up_mask) ? up_sel : any_sel;

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_next = (s_tuser[0] == ACT_DEQUEUE) ? ST_SQUARE : ST_ENQ;
				end
			end
			ST_ENQ:    state_next = ST_OUT;
			ST_SQUARE: state_next = ST_DIV100;
			ST_DIV100: state_next = ST_DIV10K;
			ST_DIV10K: state_next = ST_MOD10K;
			ST_MOD10K: state_next = ST_DIV101;
			ST_DIV101: state_next = ST_MOD101;
			ST_MOD101: state_next = ST_PICK;
			ST_PICK:   state_next = ST_OUT;
			ST_OUT: begin
				if (out_load) begin
					state_next = ST_IDLE;
				end
			end
			default:   state_next = ST_IDLE;
		endcase
	end

	// Sequencer outputs: handshake, multiplier operands, memory strobes.
	always_comb begin
		s_tready  = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = ADDR_W'(enq_lv) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(enq_tail);
		mem_raddr = ADDR_W'(sel_lv) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[sel_lv]);
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_ENQ:    mem_we = prio_ok && !enq_full;
			ST_SQUARE: begin
				mul_a = 32'(rand_q);
				mul_b = 32'(rand_q);
			end
			ST_DIV100: begin
				mul_a = 32'(wk_q);
				mul_b = RECIP_100;
			end
			ST_DIV10K: begin
				mul_a = 32'(quo_q);
				mul_b = RECIP_10000;
			end
			ST_MOD10K: begin
				mul_a = 32'(wk_q);
				mul_b = CONST_10000;
			end
			ST_DIV101: begin
				mul_a = 32'(rand_q);
				mul_b = RECIP_101;
			end
			ST_MOD101: begin
				mul_a = 32'(wk_q);
				mul_b = CONST_101;
			end
			ST_PICK:   mem_re = found;
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Input item capture and arithmetic work registers.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			act_q  <= s_tuser[0];
			pid_q  <= s_tdata[31:0];
			prio_q <= s_tdata[35:32];
		end
		case (state_q)
			ST_SQUARE: wk_q       <= prod[27:0];
			ST_DIV100: quo_q      <= prod[SHIFT_100 +: 22];
			ST_DIV10K: wk_q       <= prod[SHIFT_10000 +: 28];
			ST_DIV101: wk_q       <= prod[SHIFT_101 +: 28];
			ST_MOD101: pick_val_q <= PICK_W'(rand_q - prod[RAND_W-1:0]);
			default: begin
				wk_q <= wk_q;
			end
		endcase
	end

	// Queue bookkeeping and the random state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				count_q[i] <= '0;
				head_q[i]  <= '0;
				tail_q[i]  <= '0;
			end
			rand_q <= RANDOM_SEED;
		end else begin
			if (mem_we) begin
				count_q[enq_lv] <= enq_cnt + CNT_W'(1);
				tail_q[enq_lv]  <= wrap_next(enq_tail);
			end
			if (mem_re) begin
				count_q[sel_lv] <= count_q[sel_lv] - CNT_W'(1);
				head_q[sel_lv]  <= wrap_next(head_q[sel_lv]);
			end
			if (state_q == ST_MOD10K) begin
				rand_q <= mod10k_diff[RAND_W-1:0];
			end
		end
	end

	// Result fields, decided before the output stage.
	always_ff @(posedge clk) begin
		if (state_q == ST_ENQ) begin
			res_level_q <= '0;
			if (!prio_ok) begin
				res_status_q <= STAT_BAD_PRIO;
			end else if (enq_full) begin
				res_status_q <= STAT_FULL;
			end else begin
				res_status_q <= STAT_ENQUEUED;
			end
		end else if (state_q == ST_PICK) begin
			res_level_q  <= found ? sel_lv : '0;
			res_status_q <= found ? STAT_DEQUEUED : STAT_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_id_q     <= (res_status_q == STAT_DEQUEUED) ? mem_rdata : '0;
			m_level_q  <= res_level_q;
			m_status_q <= res_status_q;
		end
	end

	wrps_queue_mem #(
		.WORDS  (WORDS),
		.ADDR_W (ADDR_W),
		.DATA_W (ID_W)
	) u_queue_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (pid_q),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'd0, m_level_q, m_id_q};
	assign m_tuser  = m_status_q;

	// The action captured at acceptance steers the sequencer into the matching path.
	a_path_matches_action: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENQ || state_q == ST_SQUARE) |->
			((state_q == ST_SQUARE) == (act_q == ACT_DEQUEUE)))
		else $error("sequencer path does not match captured action");

	a_rand_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rand_q < RAND_W'(10000))
		else $error("random state left the range below 10000");

	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PICK) |-> (pick_val_q <= PICK_W'(100)))
		else $error("remainder by 101 out of range");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (enq_cnt < CNT_W'(QUEUE_DEPTH)) && !mem_re)
		else $error("queue write while full or together with a read");

	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (count_q[sel_lv] != '0))
		else $error("read from an empty level");

endmodule
